FILE: hw/rtl/fxp_pkg.sv
`default_nettype none

package fxp_pkg;

  // Significand of the slope 12102203.0. The value is an integer below 2^24, so its
  // exponent is zero and the significand is the value itself.
  localparam logic [23:0] SLOPE_SIG = 24'd12102203;

  // Reset values of the configuration registers.
  localparam logic [31:0] MAGIC_RESET  = 32'd1064866360;
  localparam logic        HALVED_RESET = 1'b1;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_MAGIC  = 1'b0,
    REG_HALVED = 1'b1
  } cfg_reg_t;

  // Class of a binary32 operand, as far as this datapath cares.
  typedef enum logic [1:0] {
    CLS_ZERO = 2'd0,
    CLS_NORM = 2'd1,
    CLS_INF  = 2'd2,
    CLS_NAN  = 2'd3
  } fp_cls_t;

  // Raw square of a normal significand and its biased result exponent before
  // normalization.
  typedef struct packed {
    logic [47:0]       prod;
    logic signed [9:0] exp_b;
  } sq_prod_t;

endpackage

`default_nettype wire

FILE: hw/rtl/fxp_sq_round.sv
`default_nettype none

module fxp_sq_round import fxp_pkg::*; (
  input  wire sq_prod_t    sq_in,
  output logic [30:0]      mag_bits
);

  logic [47:0]       norm;
  logic signed [9:0] eb;
  logic [9:0]        shamt_full;
  logic [4:0]        shamt;
  logic [47:0]       kept_all;
  logic [47:0]       lost_mask;
  logic [23:0]       kept;
  logic              guard;
  logic              sticky;
  logic              inc;
  logic [24:0]       rnd;
  logic [7:0]        exp_base;
  logic [31:0]       packed_sum;

  // Normalize so the leading one sits at bit 47, then fold that shift into the exponent.
  always_comb begin
    if (sq_in.prod[47]) begin
      norm = sq_in.prod;
      eb   = sq_in.exp_b + 10'sd1;
    end else begin
      norm = {sq_in.prod[46:0], 1'b0};
      eb   = sq_in.exp_b;
    end
  end

  // A result below the normal range is shifted right into subnormal position.
  always_comb begin
    if (eb >= 10'sd1) begin
      shamt_full = 10'd0;
      exp_base   = (eb >= 10'sd255) ? 8'd254 : 8'(eb - 10'sd1);
    end else begin
      shamt_full = 10'(10'sd1 - eb);
      exp_base   = 8'd0;
    end
    shamt     = (shamt_full > 10'd31) ? 5'd31 : shamt_full[4:0];
    kept_all  = norm >> shamt;
    lost_mask = ~({48{1'b1}} << shamt);
  end

  // Round to nearest even and add the rounded significand onto the exponent field, so a
  // carry out of the significand bumps the exponent.
  always_comb begin
    kept       = kept_all[47:24];
    guard      = kept_all[23];
    sticky     = (|kept_all[22:0]) | (|(norm & lost_mask));
    inc        = guard & (sticky | kept[0]);
    rnd        = {1'b0, kept} + {24'd0, inc};
    packed_sum = {1'b0, exp_base, 23'd0} + {7'd0, rnd};
    if (eb >= 10'sd255 || packed_sum[30:23] == 8'hFF) begin
      mag_bits = {8'hFF, 23'd0};
    end else begin
      mag_bits = packed_sum[30:0];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/fast_exp_bit_trick_approx.sv
// Approximate e^x on binary32 bit patterns by the integer bit trick.
// Input channel: in_valid / in_ready / in_operand_bits, one binary32 operand per transfer.
// Output channel: out_valid / out_ready / out_result_bits, one binary32 result per
// transfer, in input order.
// Configuration: cfg_we writes cfg_data into register cfg_index (0: magic offset,
// 1: halved mode). Write only while the pipeline is empty.
// Each input transfer passes through stages 0 to 5 in turn before showing on out_valid.
// Throughput: one operand per clock while out_ready is high. Each of the six pipeline
// stages holds one item, and the clock rate is set by the two 24x24 multipliers and the
// round and shift logic between them.
// When the receiver stalls, each stage holds its item. Stages that are empty keep taking
// items, so in_ready drops only once all six stages are full and out_ready is low.
// Reset empties the pipeline and sets magic offset to 1064866360 and halved mode to 1.
`default_nettype none

module fast_exp_bit_trick_approx import fxp_pkg::*; (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [31:0] in_operand_bits,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [31:0] out_result_bits,
  input  wire         cfg_we,
  input  wire  [0:0]  cfg_index,
  input  wire  [31:0] cfg_data
);

  localparam int NSTG = 6;

  // Configuration registers.
  logic [31:0] magic_r;
  logic        halved_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r  <= MAGIC_RESET;
      halved_r <= HALVED_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAGIC:  magic_r  <= cfg_data;
        REG_HALVED: halved_r <= cfg_data[0];
        default:    ;
      endcase
    end
  end

  // Stage valid bits and per-stage advance enables. A stage takes new data when it is empty
  // or its content moves on.
  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] adv;

  always_comb begin
    adv[NSTG-1] = ~vld_r[NSTG-1] | out_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      adv[k] = ~vld_r[k] | adv[k+1];
    end
  end

  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (adv[k]) begin
          vld_r[k] <= (k == 0) ? in_valid : vld_r[k-1];
        end
      end
    end
  end

  // Stage 0: halve the operand in halved mode. For the lowest exponents the significand
  // shifts right and is rounded to nearest even.
  logic [31:0] x0_nxt;
  logic [31:0] x0_r;
  logic [23:0] hsig;
  logic [22:0] hq;
  logic        hrnd;

  always_comb begin
    hsig = {in_operand_bits[23], in_operand_bits[22:0]};
    hq   = hsig[23:1];
    hrnd = in_operand_bits[0] & hq[0];
    if (!halved_r || in_operand_bits[30:23] == 8'hFF) begin
      x0_nxt = in_operand_bits;
    end else if (in_operand_bits[30:23] >= 8'd2) begin
      x0_nxt = {in_operand_bits[31], in_operand_bits[30:23] - 8'd1, in_operand_bits[22:0]};
    end else begin
      x0_nxt = {in_operand_bits[31], 31'({8'd0, hq} + {30'd0, hrnd})};
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) x0_r <= x0_nxt;
  end

  // Stage 1: unpack the operand and multiply its significand by the slope.
  fp_cls_t     cls1_r;
  logic        sgn1_r;
  logic [7:0]  exp1_r;
  logic [47:0] prod1_r;
  fp_cls_t     cls1_nxt;

  always_comb begin
    if (x0_r[30:23] == 8'd0) begin
      cls1_nxt = CLS_ZERO;
    end else if (x0_r[30:23] == 8'hFF) begin
      cls1_nxt = (x0_r[22:0] != 23'd0) ? CLS_NAN : CLS_INF;
    end else begin
      cls1_nxt = CLS_NORM;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      cls1_r  <= cls1_nxt;
      sgn1_r  <= x0_r[31];
      exp1_r  <= x0_r[30:23];
      prod1_r <= {1'b1, x0_r[22:0]} * SLOPE_SIG;
    end
  end

  // Stage 2: round the product to a 24-bit significand. Its value is rnd * 2^scl.
  logic [24:0]       rnd2_r;
  logic signed [9:0] scl2_r;
  fp_cls_t           cls2_r;
  logic              sgn2_r;
  logic [47:0]       n2;
  logic              t2;
  logic              inc2;

  always_comb begin
    t2   = prod1_r[47];
    n2   = t2 ? prod1_r : {prod1_r[46:0], 1'b0};
    inc2 = n2[23] & ((|n2[22:0]) | n2[24]);
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      rnd2_r <= {1'b0, n2[47:24]} + {24'd0, inc2};
      scl2_r <= $signed({2'b00, exp1_r}) - 10'sd127 + $signed({9'd0, t2});
      cls2_r <= cls1_r;
      sgn2_r <= sgn1_r;
    end
  end

  // Stage 3: truncate toward zero to int32 with saturation, then add the magic offset.
  logic [31:0] sum3_r;
  logic [32:0] up3;
  logic [9:0]  dn3;
  logic [31:0] mag3;
  logic        sat3;
  logic [31:0] int3;

  always_comb begin
    up3  = {8'd0, rnd2_r} << scl2_r[2:0];
    dn3  = 10'(-scl2_r);
    mag3 = '0;
    sat3 = 1'b0;
    if (scl2_r >= 10'sd8) begin
      sat3 = 1'b1;
    end else if (scl2_r >= 10'sd0) begin
      sat3 = (up3[32:31] != 2'b00);
      mag3 = up3[31:0];
    end else if (dn3 <= 10'd24) begin
      mag3 = {7'd0, rnd2_r >> dn3[4:0]};
    end
    case (cls2_r)
      CLS_NORM: begin
        if (sat3) begin
          int3 = sgn2_r ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
          int3 = sgn2_r ? (~mag3 + 32'd1) : mag3;
        end
      end
      CLS_INF: int3 = sgn2_r ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: int3 = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[3]) sum3_r <= int3 + magic_r;
  end

  // Stage 4: in halved mode square the approximation. NaN, zero, subnormal, infinity and
  // the plain mode bypass the multiplier.
  logic        byp4_r;
  logic [31:0] byp4_val_r;
  sq_prod_t    sq4_r;
  logic        byp4_nxt;
  logic [31:0] byp4_val_nxt;

  always_comb begin
    byp4_nxt     = 1'b1;
    byp4_val_nxt = sum3_r;
    if (halved_r) begin
      if (sum3_r[30:23] == 8'hFF) begin
        byp4_val_nxt = (sum3_r[22:0] != 23'd0) ? (sum3_r | 32'h0040_0000) : 32'h7F80_0000;
      end else if (sum3_r[30:23] == 8'd0) begin
        byp4_val_nxt = 32'd0;
      end else begin
        byp4_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      byp4_r        <= byp4_nxt;
      byp4_val_r    <= byp4_val_nxt;
      sq4_r.prod    <= {1'b1, sum3_r[22:0]} * {1'b1, sum3_r[22:0]};
      sq4_r.exp_b   <= $signed({1'b0, sum3_r[30:23], 1'b0}) - 10'sd127;
    end
  end

  // Stage 5: round the square and hold the result for the receiver.
  logic [30:0] sq5_bits;
  logic [31:0] res5_r;

  fxp_sq_round u_sq_round (
    .sq_in    (sq4_r),
    .mag_bits (sq5_bits)
  );

  always_ff @(posedge clk) begin
    if (adv[5]) res5_r <= byp4_r ? byp4_val_r : {1'b0, sq5_bits};
  end

  assign out_valid       = vld_r[NSTG-1];
  assign out_result_bits = res5_r;

  // An empty output stage means the pipeline can take an item.
  a_empty_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("in_ready low while the output stage is empty");

  // Back pressure reaches the input only when every stage is full.
  a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (&vld_r) && !out_ready)
    else $error("input blocked with a bubble in the pipeline");

  // With the receiver ready, an item in stage 4 reaches the output next cycle.
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready && vld_r[NSTG-2] |=> out_valid)
    else $error("item lost between the last two stages");

endmodule

`default_nettype wire

FILE: tb/fast_exp_bit_trick_approx_checker.sv
`default_nettype none

// Watches both channels and the configuration port, predicts each result from the
// accepted operand and compares it with what the block delivers.
module fast_exp_bit_trick_approx_checker import fxp_pkg::*; (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  input  wire         in_ready,
  input  wire  [31:0] in_operand_bits,
  input  wire         out_valid,
  input  wire         out_ready,
  input  wire  [31:0] out_result_bits,
  input  wire         cfg_we,
  input  wire  [0:0]  cfg_index,
  input  wire  [31:0] cfg_data,
  output int          mismatch_count,
  output int          pending_count,
  output int          result_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam real SLOPE = 12102203.0;

  logic [31:0] magic_q;
  logic        halved_q;
  logic [31:0] expected_results[$];

  // Widens a binary32 pattern to a real; subnormals are built by an exact scaling.
  function automatic real f32_to_real(input logic [31:0] b);
    real r;
    if (b[30:23] == 8'hFF) begin
      return $bitstoreal({b[31], 11'h7FF, b[22:0], 29'h0});
    end
    if (b[30:23] == 8'h00) begin
      r = real'(b[22:0]) * (2.0 ** (-149));
      return b[31] ? -r : r;
    end
    return $bitstoreal({b[31], 11'(int'(b[30:23]) - 127 + 1023), b[22:0], 29'h0});
  endfunction

  // Rounds a real to binary32, nearest-even, with overflow and subnormal handling.
  function automatic logic [31:0] real_to_f32(input real r);
    logic [63:0] d;
    logic        s;
    int          ex;
    int          sh;
    logic [52:0] sig;
    logic [52:0] kept;
    logic [31:0] body;
    logic        g;
    logic        st;
    d = $realtobits(r);
    s = d[63];
    if (d[62:52] == 11'h7FF) begin
      return (d[51:0] != 0) ? {s, 8'hFF, 23'h400000} : {s, 8'hFF, 23'h0};
    end
    if (d[62:52] == 11'h000) return {s, 31'h0};
    ex  = int'(d[62:52]) - 1023;
    sig = {1'b1, d[51:0]};
    if (ex > 127) return {s, 8'hFF, 23'h0};
    if (ex >= -126) begin
      body = {1'b0, 8'(ex + 127), sig[51:29]};
      g    = sig[28];
      st   = |sig[27:0];
    end else begin
      sh = 29 + (-126 - ex);
      if (sh > 53) return {s, 31'h0};
      kept = sig >> sh;
      g    = sig[sh-1];
      st   = (sig & ((53'd1 << (sh - 1)) - 53'd1)) != 0;
      body = 32'(kept);
    end
    // A carry out of the significand moves into the exponent, up to infinity.
    if (g && (st || body[0])) body = body + 32'd1;
    return {s, body[30:0]};
  endfunction

  // Truncates a binary32 value toward zero to int32, saturating; NaN gives zero.
  function automatic logic [31:0] f32_to_int32(input logic [31:0] p);
    logic [31:0] mag;
    int          e;
    e = int'(p[30:23]);
    if (e == 255 && p[22:0] != 0) return 32'h0;
    if (e >= 158) return p[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    if (e < 127) return 32'h0;
    mag = {8'h0, 1'b1, p[22:0]};
    if (e >= 150) mag = mag << (e - 150);
    else mag = mag >> (150 - e);
    return p[31] ? -mag : mag;
  endfunction

  function automatic logic [31:0] bit_trick(input logic [31:0] x);
    return f32_to_int32(real_to_f32(SLOPE * f32_to_real(x))) + magic_q;
  endfunction

  // Expected result for one operand under the present configuration.
  function automatic logic [31:0] exp_estimate(input logic [31:0] x);
    logic [31:0] half;
    logic [31:0] approx;
    real         a;
    if (!halved_q) return bit_trick(x);
    half   = real_to_f32(f32_to_real(x) / 2.0);
    approx = bit_trick(half);
    if (approx[30:23] == 8'hFF && approx[22:0] != 0) return approx | 32'h0040_0000;
    a = f32_to_real(approx);
    return real_to_f32(a * a);
  endfunction

  assign pending_count = expected_results.size();

  // Track configuration writes, queue predictions and compare each result transfer.
  always @(posedge clk) begin
    logic [31:0] want;
    if (!rst_n) begin
      magic_q        = MAGIC_RESET;
      halved_q       = HALVED_RESET;
      mismatch_count = 0;
      result_count   = 0;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_MAGIC: begin
            magic_q = cfg_data;
          end
          REG_HALVED: begin
            halved_q = cfg_data[0];
          end
          default: begin
          end
        endcase
      end
      if (in_valid && in_ready) expected_results.push_back(exp_estimate(in_operand_bits));
      if (out_valid && out_ready) begin
        result_count++;
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("[%0t] unexpected result transfer: %08h", $time, out_result_bits);
        end else begin
          want = expected_results.pop_front();
          if (want !== out_result_bits) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("[%0t] result_bits mismatch: expected %08h, got %08h",
                       $time, want, out_result_bits);
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: tb/fast_exp_bit_trick_approx_tb.sv
`default_nettype none

module fast_exp_bit_trick_approx_tb import fxp_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 80;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_operand_bits = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_result_bits;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = REG_MAGIC;
  logic [31:0] cfg_data = '0;

  int   mismatch_count;
  int   pending_count;
  int   result_count;
  int   cycle_count = 0;
  int   operands_sent = 0;
  logic calm = 1'b0;
  logic hold_go = 1'b0;
  int   hold_left = 0;

  fast_exp_bit_trick_approx u_dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_operand_bits,
    .out_valid, .out_ready, .out_result_bits, .cfg_we, .cfg_index, .cfg_data
  );

  fast_exp_bit_trick_approx_checker u_checker (
    .clk, .rst_n, .in_valid, .in_ready, .in_operand_bits,
    .out_valid, .out_ready, .out_result_bits, .cfg_we, .cfg_index, .cfg_data,
    .mismatch_count, .pending_count, .result_count
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Give up when the run takes far longer than any correct run could.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Receiver: random stalls, a long hold-off on request, none while calm.
  always @(negedge clk) begin
    if (hold_go && hold_left == 0) hold_left = HOLD_CYCLES;
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
      if (hold_left == 0) hold_go = 1'b0;
    end else if (calm) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= 26);
    end
  end

  // Offers one operand and holds it until the transfer; called at a falling edge.
  task automatic send_operand(input logic [31:0] bits);
    logic taken;
    while (!calm && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_operand_bits <= bits;
    do begin
      @(posedge clk);
      taken = in_ready;
      @(negedge clk);
    end while (!taken);
    operands_sent++;
  endtask

  // Writes one register while the pipeline is empty.
  task automatic write_reg(input cfg_reg_t idx, input logic [31:0] value);
    in_valid  <= 1'b0;
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Random operand: mostly moderate arguments, some raw patterns and specials.
  function automatic logic [31:0] random_operand;
    int pick;
    pick = $urandom_range(99);
    if (pick < 55) return {1'($urandom), 8'($urandom_range(133, 100)), 23'($urandom)};
    if (pick < 65) return {1'($urandom), 8'($urandom_range(160, 134)), 23'($urandom)};
    if (pick < 72) return {1'($urandom), 8'hFF, 23'($urandom_range(1, 1))} ^
                          {9'h0, 23'($urandom)};
    if (pick < 76) return {1'($urandom), 8'h00, 23'($urandom)};
    return $urandom;
  endfunction

  logic [31:0] corner_operands[] = '{
    32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'hBF80_0000,
    32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'hFFC0_0001,
    32'h7F80_0001, 32'h7FFF_FFFF, 32'h7F7F_FFFF, 32'hFF7F_FFFF,
    32'h0000_0001, 32'h807F_FFFF, 32'h0080_0000, 32'h42C8_0000,
    32'hC348_0000, 32'h4331_7218, 32'hC331_7218, 32'h4200_0000,
    32'h3400_0000, 32'hB2FF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA
  };

  // Each entry: magic offset and halved mode; every phase also sends 65 random operands.
  logic [31:0] phase_magic[6] = '{
    MAGIC_RESET, MAGIC_RESET, 32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0
  };
  logic        phase_halved[6] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    for (int ph = 0; ph < 6; ph++) begin
      // The first phase runs on reset values; the last picks a random offset.
      if (ph > 0) begin
        drain();
        write_reg(REG_MAGIC, (ph == 5) ? $urandom : phase_magic[ph]);
        write_reg(REG_HALVED, {31'h0, phase_halved[ph]});
      end
      calm    = (ph == 3);
      hold_go = (ph == 2);
      if (ph < 2) begin
        foreach (corner_operands[i]) send_operand(corner_operands[i]);
      end
      for (int k = 0; k < 65; k++) send_operand(random_operand());
    end
    calm = 1'b0;
    drain();
    $display("sent %0d operands over six register settings, %0d results checked",
             operands_sent, result_count);
    $display("offsets included both int32 extremes, with halved mode on and off");
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
